// File: src/upp_pkg.sv
// Shared types, constants and the control store of the unicycle pose predictor.
// Holds the microcode program, the CORDIC arctangent table and small helpers.
// No dependencies.
package upp_pkg;

   localparam int UPP_ANGLE_BITS    = 16;
   localparam int UPP_POSITION_BITS = 32;

   localparam logic [15:0] TIME_STEP_RESET = 16'd655;

   // Rotation unit: 24 iterations on Q2.30 vectors and a 32-bit binary angle.
   localparam int CORDIC_STEPS  = 24;
   localparam int ITER_BITS     = $clog2(CORDIC_STEPS + 1);
   localparam int ATAN_IDX_BITS = $clog2(CORDIC_STEPS);
   localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;
   localparam logic signed [31:0] ATAN_TAB [CORDIC_STEPS] = '{
      32'sh2000_0000, 32'sh12E4_051E, 32'sh09FB_385B, 32'sh0511_11D4,
      32'sh028B_0D43, 32'sh0145_D7E1, 32'sh00A2_F61E, 32'sh0051_7C55,
      32'sh0028_BE53, 32'sh0014_5F2F, 32'sh000A_2F98, 32'sh0005_17CC,
      32'sh0002_8BE6, 32'sh0001_45F3, 32'sh0000_A2FA, 32'sh0000_517D,
      32'sh0000_28BE, 32'sh0000_145F, 32'sh0000_0A30, 32'sh0000_0518,
      32'sh0000_028C, 32'sh0000_0146, 32'sh0000_00A3, 32'sh0000_0051
   };

   // Shared multiplier: 33-bit signed by 18-bit signed.
   localparam int MUL_A_W = 33;
   localparam int MUL_B_W = 18;
   localparam int MUL_W   = MUL_A_W + MUL_B_W;
   localparam int VDT_W   = 48;
   localparam int ACC_W   = 42;
   localparam int SUM_W   = 66;
   localparam int DPOS_W  = 33;
   localparam int TRIG_W  = 18;

   typedef struct packed {
      logic init;
      logic step;
      logic round;
   } cordic_ctrl_type;

   typedef enum logic [2:0] {
      MA_ZERO, MA_SPEED, MA_TURN, MA_TSTEP, MA_VDT_LO, MA_VDT_HI
   } mul_a_type;

   typedef enum logic [1:0] {
      MB_ZERO, MB_TSTEP, MB_COS, MB_SIN
   } mul_b_type;

   typedef enum logic [2:0] {
      WB_NONE, WB_VDT, WB_HEADING, WB_JXV, WB_JYV, WB_ACC, WB_DX, WB_DY
   } wb_type;

   typedef enum logic [1:0] {
      FIN_NONE, FIN_ADVANCE, FIN_LOAD
   } fin_type;

   typedef enum logic [1:0] {
      JUMP_NEXT, JUMP_LOOP, JUMP_DONE
   } jump_type;

   localparam int PC_BITS = 4;

   localparam logic [PC_BITS-1:0] PC_ADVANCE = 4'd0;
   localparam logic [PC_BITS-1:0] PC_VDT     = 4'd1;
   localparam logic [PC_BITS-1:0] PC_HEAD    = 4'd2;
   localparam logic [PC_BITS-1:0] PC_LOOP    = 4'd3;
   localparam logic [PC_BITS-1:0] PC_ROUND   = 4'd4;
   localparam logic [PC_BITS-1:0] PC_DTCOS   = 4'd5;
   localparam logic [PC_BITS-1:0] PC_DTSIN   = 4'd6;
   localparam logic [PC_BITS-1:0] PC_XLO     = 4'd7;
   localparam logic [PC_BITS-1:0] PC_XHI     = 4'd8;
   localparam logic [PC_BITS-1:0] PC_YLO     = 4'd9;
   localparam logic [PC_BITS-1:0] PC_YHI     = 4'd10;
   localparam logic [PC_BITS-1:0] PC_DY      = 4'd11;
   localparam logic [PC_BITS-1:0] PC_FINISH  = 4'd12;
   localparam logic [PC_BITS-1:0] PC_LOAD    = 4'd13;

   // One control word. A multiply issued in one step is written back by the
   // wb field of the following step.
   typedef struct packed {
      cordic_ctrl_type    cordic;
      mul_a_type          a_sel;
      mul_b_type          b_sel;
      wb_type             wb;
      fin_type            fin;
      jump_type           jump;
      logic [PC_BITS-1:0] target;
   } ucode_type;

   localparam ucode_type UCODE_IDLE = '{
      cordic: '0, a_sel: MA_ZERO, b_sel: MB_ZERO, wb: WB_NONE,
      fin: FIN_NONE, jump: JUMP_NEXT, target: '0
   };

   function automatic ucode_type ucode_rom(input logic [PC_BITS-1:0] pc);
      ucode_type w;
      w = UCODE_IDLE;
      case (pc)
         PC_ADVANCE: begin
            w.cordic.init = 1'b1;
            w.a_sel = MA_SPEED;
            w.b_sel = MB_TSTEP;
         end
         PC_VDT: begin
            w.cordic.step = 1'b1;
            w.wb = WB_VDT;
            w.a_sel = MA_TURN;
            w.b_sel = MB_TSTEP;
         end
         PC_HEAD: begin
            w.cordic.step = 1'b1;
            w.wb = WB_HEADING;
         end
         PC_LOOP: begin
            w.cordic.step = 1'b1;
            w.jump = JUMP_LOOP;
            w.target = PC_LOOP;
         end
         PC_ROUND: begin
            w.cordic.round = 1'b1;
         end
         PC_DTCOS: begin
            w.a_sel = MA_TSTEP;
            w.b_sel = MB_COS;
         end
         PC_DTSIN: begin
            w.wb = WB_JXV;
            w.a_sel = MA_TSTEP;
            w.b_sel = MB_SIN;
         end
         PC_XLO: begin
            w.wb = WB_JYV;
            w.a_sel = MA_VDT_LO;
            w.b_sel = MB_COS;
         end
         PC_XHI: begin
            w.wb = WB_ACC;
            w.a_sel = MA_VDT_HI;
            w.b_sel = MB_COS;
         end
         PC_YLO: begin
            w.wb = WB_DX;
            w.a_sel = MA_VDT_LO;
            w.b_sel = MB_SIN;
         end
         PC_YHI: begin
            w.wb = WB_ACC;
            w.a_sel = MA_VDT_HI;
            w.b_sel = MB_SIN;
         end
         PC_DY: begin
            w.wb = WB_DY;
         end
         PC_FINISH: begin
            w.fin = FIN_ADVANCE;
            w.jump = JUMP_DONE;
         end
         PC_LOAD: begin
            w.fin = FIN_LOAD;
            w.jump = JUMP_DONE;
         end
         default: begin
            w = UCODE_IDLE;
         end
      endcase
      return w;
   endfunction

   function automatic logic signed [31:0] sat_q32(input logic signed [33:0] v);
      logic signed [31:0] r;
      if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
         r = v[31:0];
      end else if (v[33]) begin
         r = 32'sh8000_0000;
      end else begin
         r = 32'sh7FFF_FFFF;
      end
      return r;
   endfunction

endpackage

// File: src/upp_req_if.sv
// Request channel of the pose predictor: valid/ready plus one item's fields.
// No dependencies.
interface upp_req_if;
   logic               valid;
   logic               ready;
   logic               action;
   logic signed [31:0] speed;
   logic signed [31:0] turn_rate;
   logic signed [31:0] load_x;
   logic signed [31:0] load_y;
   logic signed [15:0] load_heading;

   modport source(output valid, action, speed, turn_rate, load_x, load_y, load_heading,
                  input ready);
   modport sink(input valid, action, speed, turn_rate, load_x, load_y, load_heading,
                output ready);
endinterface

// File: src/upp_rsp_if.sv
// Response channel of the pose predictor: valid/ready plus pose and Jacobian terms.
// No dependencies.
interface upp_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pose_x;
   logic signed [31:0] pose_y;
   logic signed [15:0] pose_heading;
   logic signed [31:0] dx_dheading;
   logic signed [31:0] dy_dheading;
   logic signed [17:0] dx_dspeed;
   logic signed [17:0] dy_dspeed;

   modport source(output valid, pose_x, pose_y, pose_heading, dx_dheading, dy_dheading,
                  dx_dspeed, dy_dspeed, input ready);
   modport sink(input valid, pose_x, pose_y, pose_heading, dx_dheading, dy_dheading,
                dx_dspeed, dy_dspeed, output ready);
endinterface

// File: src/upp_csr_if.sv
// Register write channel of the pose predictor: valid/ready plus the step duration.
// No dependencies.
interface upp_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] time_step;

   modport source(output valid, time_step, input ready);
   modport sink(input valid, time_step, output ready);
endinterface

// File: src/upp_cordic.sv
// Iterative CORDIC rotation unit: cosine and sine of a binary angle in Q16.
// Depends on upp_pkg; stepped one iteration per cycle by the sequencer.
module upp_cordic
   import upp_pkg::*;
#(
   parameter int ANGLE_BITS = UPP_ANGLE_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cordic_ctrl_type          ctrl,
   input  logic [ANGLE_BITS-1:0]    angle,
   output logic                     last,
   output logic signed [TRIG_W-1:0] cos_q16,
   output logic signed [TRIG_W-1:0] sin_q16
);

   logic signed [31:0]        x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic                      flip_ff, flip_in;
   logic [ITER_BITS-1:0]      iter_ff, iter_in;
   logic signed [TRIG_W-1:0]  cos_ff, cos_in, sin_ff, sin_in;
   logic [31:0]               angle32;
   logic                      fold;
   logic signed [31:0]        x_shift, y_shift, atan_val;

   function automatic logic signed [TRIG_W-1:0] to_q16(input logic signed [31:0] v);
      logic signed [31:0]       s;
      logic signed [TRIG_W-1:0] q;
      s = v + 32'sd8192;
      q = s[31:14];
      if (q > 18'sd65536) begin
         q = 18'sd65536;
      end else if (q < -18'sd65536) begin
         q = -18'sd65536;
      end
      return q;
   endfunction

   // Angles in the left half plane are rotated by pi and the result negated.
   assign angle32 = {angle, {(32 - ANGLE_BITS){1'b0}}};
   assign fold    = angle[ANGLE_BITS-1] ^ angle[ANGLE_BITS-2];
   assign x_shift = x_ff >>> iter_ff;
   assign y_shift = y_ff >>> iter_ff;
   assign atan_val = ATAN_TAB[iter_ff[ATAN_IDX_BITS-1:0]];

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      flip_in = flip_ff;
      iter_in = iter_ff;
      cos_in  = cos_ff;
      sin_in  = sin_ff;
      if (ctrl.init) begin
         x_in    = CORDIC_X0;
         y_in    = '0;
         z_in    = {angle32[31] ^ fold, angle32[30:0]};
         flip_in = fold;
         iter_in = '0;
      end else if (ctrl.step) begin
         if (!z_ff[31]) begin
            x_in = x_ff - y_shift;
            y_in = y_ff + x_shift;
            z_in = z_ff - atan_val;
         end else begin
            x_in = x_ff + y_shift;
            y_in = y_ff - x_shift;
            z_in = z_ff + atan_val;
         end
         iter_in = iter_ff + 1'b1;
      end
      if (ctrl.round) begin
         cos_in = to_q16(flip_ff ? -x_ff : x_ff);
         sin_in = to_q16(flip_ff ? -y_ff : y_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         iter_ff <= '0;
      end else begin
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      flip_ff <= flip_in;
      cos_ff  <= cos_in;
      sin_ff  <= sin_in;
   end

   assign last    = (iter_ff == ITER_BITS'(CORDIC_STEPS - 1));
   assign cos_q16 = cos_ff;
   assign sin_q16 = sin_ff;

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |-> iter_ff < ITER_BITS'(CORDIC_STEPS))
      else $error("rotation step issued after the last iteration");

   a_round_complete: assert property (@(posedge clock) disable iff (reset)
      ctrl.round |-> iter_ff == ITER_BITS'(CORDIC_STEPS))
      else $error("rounding before all iterations were done");

   a_trig_bounded: assert property (@(posedge clock) disable iff (reset)
      ctrl.round |=> (cos_ff <= 18'sd65536 && cos_ff >= -18'sd65536 &&
                      sin_ff <= 18'sd65536 && sin_ff >= -18'sd65536))
      else $error("cosine or sine out of the unit range");

endmodule

// File: src/unicycle_pose_predictor_core.sv
// Top level of the unicycle pose predictor: microcode sequencer and datapath.
// Depends on upp_pkg, the three channel interfaces and upp_cordic.
//
// Usage: req_ch carries one item per beat. action 0 advances the pose held
// inside by one control step using speed and turn_rate; action 1 loads the
// pose from load_x, load_y and load_heading. Every item gives exactly one
// beat on rsp_ch with the new pose and the Jacobian terms at the heading held
// before the step (all zero for a load). csr_ch writes the step duration.
// An advance runs 34 microcode steps: 24 are the rotation unit iterations,
// and eight steps each issue one product on the single 33x18 multiplier.
// The result is registered by the finishing step (PC_FINISH for an advance,
// PC_LOAD for a load), and req_ch.ready returns in the same cycle, so the
// block takes no new item until the previous one has finished.
// The result register lets the next item start while a result still waits;
// if the receiver stalls, that next item holds at its finishing step until
// the waiting beat is taken.
// Reset (synchronous) clears the pose to zero, sets the step duration to 655
// and empties the block; no item is in flight afterward.
module unicycle_pose_predictor_core
   import upp_pkg::*;
#(
   parameter int ANGLE_BITS    = UPP_ANGLE_BITS,
   parameter int POSITION_BITS = UPP_POSITION_BITS
) (
   input  logic        clock,
   input  logic        reset,
   upp_req_if.sink     req_ch,
   upp_rsp_if.source   rsp_ch,
   upp_csr_if.sink     csr_ch
);

   localparam int PW = (POSITION_BITS > DPOS_W ? POSITION_BITS : DPOS_W) + 1;
   localparam int XO = POSITION_BITS > 32 ? POSITION_BITS : 32;
   localparam int HW = ANGLE_BITS > 16 ? ANGLE_BITS : 16;
   localparam logic signed [PW-1:0] POS_MAX =
      {{(PW - POSITION_BITS + 1){1'b0}}, {(POSITION_BITS - 1){1'b1}}};
   localparam logic signed [PW-1:0] POS_MIN =
      {{(PW - POSITION_BITS + 1){1'b1}}, {(POSITION_BITS - 1){1'b0}}};

   // Sequencer
   logic               busy_ff, busy_in;
   logic [PC_BITS-1:0] pc_ff, pc_in;
   ucode_type          uc;
   logic               req_fire, finish, stall;

   // Register and captured item
   logic [15:0]        time_step_ff, time_step_in;
   logic signed [31:0] speed_ff, turn_rate_ff, load_x_ff, load_y_ff;
   logic signed [15:0] load_heading_ff;

   // Datapath
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_W-1:0]   mul_p_ff, mul_p_in;
   logic signed [VDT_W-1:0]   vdt_ff, vdt_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic signed [DPOS_W-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [TRIG_W-1:0]  jxv_ff, jxv_in, jyv_ff, jyv_in;
   logic [MUL_W-1:0]          head_sum, jac_sum;
   logic signed [SUM_W-1:0]   pos_sum;
   logic                      cordic_last;
   logic signed [TRIG_W-1:0]  cos_q16, sin_q16;

   // Pose state
   logic signed [POSITION_BITS-1:0] x_pos_ff, x_pos_in, y_pos_ff, y_pos_in;
   logic signed [POSITION_BITS-1:0] x_next, y_next;
   logic [ANGLE_BITS-1:0]           heading_ff, heading_in, heading_load, heading_next;
   logic signed [HW-1:0]            load_head_ext, head_out_ext;
   logic signed [XO-1:0]            x_out_ext, y_out_ext;

   // Result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] out_x_ff, out_x_in, out_y_ff, out_y_in;
   logic signed [15:0] out_head_ff, out_head_in;
   logic signed [31:0] out_jxh_ff, out_jxh_in, out_jyh_ff, out_jyh_in;
   logic signed [17:0] out_jxv_ff, out_jxv_in, out_jyv_ff, out_jyv_in;

   function automatic logic signed [POSITION_BITS-1:0] sat_pos(
      input logic signed [PW-1:0] v);
      logic signed [PW-1:0] r;
      if (v > POS_MAX) begin
         r = POS_MAX;
      end else if (v < POS_MIN) begin
         r = POS_MIN;
      end else begin
         r = v;
      end
      return r[POSITION_BITS-1:0];
   endfunction

   upp_cordic #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (uc.cordic),
      .angle   (heading_ff),
      .last    (cordic_last),
      .cos_q16 (cos_q16),
      .sin_q16 (sin_q16)
   );

   // ---------------- sequencer ----------------
   assign uc       = busy_ff ? ucode_rom(pc_ff) : UCODE_IDLE;
   assign req_fire = req_ch.valid && req_ch.ready;
   assign finish   = (uc.fin != FIN_NONE);
   // A finishing step waits while the previous result has not been taken.
   assign stall    = finish && rsp_valid_ff && !rsp_ch.ready;

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (!busy_ff) begin
         if (req_fire) begin
            busy_in = 1'b1;
            pc_in   = req_ch.action ? PC_LOAD : PC_ADVANCE;
         end
      end else if (!stall) begin
         case (uc.jump)
            JUMP_NEXT: pc_in = pc_ff + 1'b1;
            JUMP_LOOP: pc_in = cordic_last ? pc_ff + 1'b1 : uc.target;
            JUMP_DONE: busy_in = 1'b0;
            default:   pc_in = pc_ff;
         endcase
      end
   end

   assign time_step_in = (csr_ch.valid && csr_ch.ready) ? csr_ch.time_step : time_step_ff;

   // ---------------- multiplier ----------------
   always_comb begin
      case (uc.a_sel)
         MA_SPEED:  mul_a = MUL_A_W'(speed_ff);
         MA_TURN:   mul_a = MUL_A_W'(turn_rate_ff);
         MA_TSTEP:  mul_a = {{(MUL_A_W - 16){1'b0}}, time_step_ff};
         MA_VDT_LO: mul_a = {{(MUL_A_W - 24){1'b0}}, vdt_ff[23:0]};
         MA_VDT_HI: mul_a = MUL_A_W'($signed(vdt_ff[VDT_W-1:24]));
         default:   mul_a = '0;
      endcase
      case (uc.b_sel)
         MB_TSTEP: mul_b = {{(MUL_B_W - 16){1'b0}}, time_step_ff};
         MB_COS:   mul_b = cos_q16;
         MB_SIN:   mul_b = sin_q16;
         default:  mul_b = '0;
      endcase
   end

   assign mul_p_in = MUL_W'(mul_a) * MUL_W'(mul_b);

   // ---------------- write back ----------------
   assign head_sum = mul_p_ff + (MUL_W'(1) << 23);
   assign jac_sum  = mul_p_ff + (MUL_W'(1) << 15);
   // The low partial product already carries the rounding constant.
   assign pos_sum  = SUM_W'(acc_ff) + (SUM_W'(mul_p_ff) <<< 24);

   always_comb begin
      vdt_in = vdt_ff;
      acc_in = acc_ff;
      dx_in  = dx_ff;
      dy_in  = dy_ff;
      jxv_in = jxv_ff;
      jyv_in = jyv_ff;
      case (uc.wb)
         WB_VDT: vdt_in = mul_p_ff[VDT_W-1:0];
         WB_JXV: jxv_in = jac_sum[33:16];
         WB_JYV: jyv_in = jac_sum[33:16];
         WB_ACC: acc_in = ACC_W'(mul_p_ff) + (ACC_W'(1) << 31);
         WB_DX:  dx_in  = pos_sum[64:32];
         WB_DY:  dy_in  = pos_sum[64:32];
         default: vdt_in = vdt_ff;
      endcase
   end

   // ---------------- pose ----------------
   assign load_head_ext = HW'(load_heading_ff);
   assign heading_load  = load_head_ext[ANGLE_BITS-1:0];

   always_comb begin
      if (uc.fin == FIN_LOAD) begin
         x_next       = sat_pos(PW'(load_x_ff));
         y_next       = sat_pos(PW'(load_y_ff));
         heading_next = heading_load;
      end else begin
         x_next       = sat_pos(PW'(x_pos_ff) + PW'(dx_ff));
         y_next       = sat_pos(PW'(y_pos_ff) + PW'(dy_ff));
         heading_next = heading_ff;
      end
   end

   always_comb begin
      x_pos_in   = x_pos_ff;
      y_pos_in   = y_pos_ff;
      heading_in = heading_ff;
      if (uc.wb == WB_HEADING) begin
         heading_in = heading_ff + head_sum[24 +: ANGLE_BITS];
      end
      if (finish && !stall) begin
         x_pos_in   = x_next;
         y_pos_in   = y_next;
         heading_in = heading_next;
      end
   end

   // ---------------- result register ----------------
   assign x_out_ext    = XO'(x_next);
   assign y_out_ext    = XO'(y_next);
   assign head_out_ext = HW'(signed'(heading_next));

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_head_in  = out_head_ff;
      out_jxh_in   = out_jxh_ff;
      out_jyh_in   = out_jyh_ff;
      out_jxv_in   = out_jxv_ff;
      out_jyv_in   = out_jyv_ff;
      if (finish && !stall) begin
         rsp_valid_in = 1'b1;
         out_x_in     = x_out_ext[31:0];
         out_y_in     = y_out_ext[31:0];
         out_head_in  = head_out_ext[15:0];
         if (uc.fin == FIN_ADVANCE) begin
            out_jxh_in = sat_q32(-(34'(dy_ff)));
            out_jyh_in = sat_q32(34'(dx_ff));
            out_jxv_in = jxv_ff;
            out_jyv_in = jyv_ff;
         end else begin
            out_jxh_in = '0;
            out_jyh_in = '0;
            out_jxv_in = '0;
            out_jyv_in = '0;
         end
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         pc_ff        <= PC_ADVANCE;
         rsp_valid_ff <= 1'b0;
         time_step_ff <= TIME_STEP_RESET;
         x_pos_ff     <= '0;
         y_pos_ff     <= '0;
         heading_ff   <= '0;
      end else begin
         busy_ff      <= busy_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
         time_step_ff <= time_step_in;
         x_pos_ff     <= x_pos_in;
         y_pos_ff     <= y_pos_in;
         heading_ff   <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         speed_ff        <= req_ch.speed;
         turn_rate_ff    <= req_ch.turn_rate;
         load_x_ff       <= req_ch.load_x;
         load_y_ff       <= req_ch.load_y;
         load_heading_ff <= req_ch.load_heading;
      end
      mul_p_ff    <= mul_p_in;
      vdt_ff      <= vdt_in;
      acc_ff      <= acc_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      jxv_ff      <= jxv_in;
      jyv_ff      <= jyv_in;
      out_x_ff    <= out_x_in;
      out_y_ff    <= out_y_in;
      out_head_ff <= out_head_in;
      out_jxh_ff  <= out_jxh_in;
      out_jyh_ff  <= out_jyh_in;
      out_jxv_ff  <= out_jxv_in;
      out_jyv_ff  <= out_jyv_in;
   end

   // ---------------- ports ----------------
   assign req_ch.ready        = !busy_ff;
   assign csr_ch.ready        = 1'b1;
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.pose_x       = out_x_ff;
   assign rsp_ch.pose_y       = out_y_ff;
   assign rsp_ch.pose_heading = out_head_ff;
   assign rsp_ch.dx_dheading  = out_jxh_ff;
   assign rsp_ch.dy_dheading  = out_jyh_ff;
   assign rsp_ch.dx_dspeed    = out_jxv_ff;
   assign rsp_ch.dy_dspeed    = out_jyv_ff;

   a_result_after_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff) && !busy_ff)
      else $error("result appeared without a finished item");

   a_stall_holds_pose: assert property (@(posedge clock) disable iff (reset)
      stall |=> busy_ff && $stable(x_pos_ff) && $stable(y_pos_ff) && $stable(heading_ff))
      else $error("pose changed while the finishing step was held");

   a_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> busy_ff && pc_ff == ($past(req_ch.action) ? PC_LOAD : PC_ADVANCE))
      else $error("accepted item did not start at its entry step");

endmodule
